// File: hdl/bad_pkg.sv
// ----------------------------------------------------------------------------
// bad_pkg
// Shared widths, register codes, reciprocal tables and control structs for
// the box average downscaler.
// ----------------------------------------------------------------------------
package bad_pkg;

    localparam int COMP_W       = 8;
    localparam int NUM_COMP_MAX = 4;
    localparam int CNT_W        = 11;
    localparam int OUT_POS_W    = 10;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 11;
    localparam int FACTOR_REG_W = 4;
    localparam int FIDX_W       = 5;
    localparam int SUM_W        = 18;
    localparam int RECIP_W      = 28;
    localparam int RECIP_SHIFT  = 27;
    localparam int WREC_W       = 17;
    localparam int WREC_SHIFT   = 16;
    localparam int MAX_HEIGHT   = 1024;
    localparam int FIFO_DEPTH   = 8;
    localparam int FIFO_PTR_W   = 3;
    localparam int FIFO_CNT_W   = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR = 2'd2;

    localparam logic [CNT_W-1:0]        WIDTH_RST  = 11'd640;
    localparam logic [CNT_W-1:0]        HEIGHT_RST = 11'd480;
    localparam logic [FACTOR_REG_W-1:0] FACTOR_RST = 4'd2;

    typedef logic [COMP_W-1:0] comp_t;

    typedef struct packed {
        logic acc;
        logic wr;
        logic first;
        logic fwd;
        logic ld_mul;
        logic mul;
    } lane_ctl_t;

    typedef struct packed {
        logic                 push;
        logic [OUT_POS_W-1:0] col;
        logic [OUT_POS_W-1:0] row;
        logic                 done;
    } res_meta_t;

    // ceil(2^27 / f^2): exact floor division for sums below 2^18
    function automatic logic [RECIP_W-1:0] area_recip(input logic [FIDX_W-1:0] f);
        logic [RECIP_W-1:0] r;
        unique case (f)
            5'd1:    r = 28'd134217728;
            5'd2:    r = 28'd33554432;
            5'd3:    r = 28'd14913081;
            5'd4:    r = 28'd8388608;
            5'd5:    r = 28'd5368710;
            5'd6:    r = 28'd3728271;
            5'd7:    r = 28'd2739138;
            5'd8:    r = 28'd2097152;
            5'd9:    r = 28'd1657009;
            5'd10:   r = 28'd1342178;
            5'd11:   r = 28'd1109238;
            5'd12:   r = 28'd932068;
            5'd13:   r = 28'd794188;
            5'd14:   r = 28'd684785;
            5'd15:   r = 28'd596524;
            5'd16:   r = 28'd524288;
            default: r = '0;
        endcase
        return r;
    endfunction

    // ceil(2^16 / f): exact floor division for sizes up to 2047
    function automatic logic [WREC_W-1:0] size_recip(input logic [FIDX_W-1:0] f);
        logic [WREC_W-1:0] r;
        unique case (f)
            5'd1:    r = 17'd65536;
            5'd2:    r = 17'd32768;
            5'd3:    r = 17'd21846;
            5'd4:    r = 17'd16384;
            5'd5:    r = 17'd13108;
            5'd6:    r = 17'd10923;
            5'd7:    r = 17'd9363;
            5'd8:    r = 17'd8192;
            5'd9:    r = 17'd7282;
            5'd10:   r = 17'd6554;
            5'd11:   r = 17'd5958;
            5'd12:   r = 17'd5462;
            5'd13:   r = 17'd5042;
            5'd14:   r = 17'd4682;
            5'd15:   r = 17'd4370;
            5'd16:   r = 17'd4096;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/bad_pix_if.sv
// ----------------------------------------------------------------------------
// bad_pix_if
// Input pixel channel: frame start flag and four components per beat.
// ----------------------------------------------------------------------------
interface bad_pix_if import bad_pkg::*;;
    logic  valid;
    logic  ready;
    logic  frame_start;
    comp_t comp0_in;
    comp_t comp1_in;
    comp_t comp2_in;
    comp_t comp3_in;

    modport source (
        output valid, frame_start, comp0_in, comp1_in, comp2_in, comp3_in,
        input  ready
    );
    modport sink (
        input  valid, frame_start, comp0_in, comp1_in, comp2_in, comp3_in,
        output ready
    );
endinterface

// File: hdl/bad_res_if.sv
// ----------------------------------------------------------------------------
// bad_res_if
// Output pixel channel: block means and position in the reduced image.
// ----------------------------------------------------------------------------
interface bad_res_if import bad_pkg::*;;
    logic                 valid;
    logic                 ready;
    comp_t                comp0_avg;
    comp_t                comp1_avg;
    comp_t                comp2_avg;
    comp_t                comp3_avg;
    logic [OUT_POS_W-1:0] out_column;
    logic [OUT_POS_W-1:0] out_row;
    logic                 frame_done;

    modport source (
        output valid, comp0_avg, comp1_avg, comp2_avg, comp3_avg,
               out_column, out_row, frame_done,
        input  ready
    );
    modport sink (
        input  valid, comp0_avg, comp1_avg, comp2_avg, comp3_avg,
               out_column, out_row, frame_done,
        output ready
    );
endinterface

// File: hdl/bad_cfg_if.sv
// ----------------------------------------------------------------------------
// bad_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bad_cfg_if import bad_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/bad_ctrl.sv
// ----------------------------------------------------------------------------
// bad_ctrl
// Config registers, reduced geometry, raster position counters and the
// control pipeline that steers the lanes and the output stage.
// ----------------------------------------------------------------------------
module bad_ctrl import bad_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_FACTOR = 8,
    parameter int AW         = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    bad_pix_if.sink               pixel,
    bad_cfg_if.sink               cfg,
    input  logic [FIFO_CNT_W-1:0] level,
    output lane_ctl_t             lane_ctl,
    output logic [AW-1:0]         rd_addr,
    output logic [AW-1:0]         wr_addr,
    output logic [RECIP_W-1:0]    recip,
    output res_meta_t             meta
);

    localparam int FW = $clog2(MAX_FACTOR + 1);

    logic [CNT_W-1:0]        img_w_reg, img_h_reg;
    logic [FACTOR_REG_W-1:0] factor_reg;
    logic                    settle_reg;

    logic [CNT_W-1:0] w_eff, h_eff, w_eff_reg, h_eff_reg;
    logic [FW-1:0]    f_eff, f_eff_reg;
    logic [CNT_W-1:0] new_w_reg, new_h_reg;
    logic [CNT_W+WREC_W-1:0] w_prod, h_prod;
    logic [WREC_W-1:0] size_rec;

    logic [CNT_W-1:0] pc_reg, pr_reg, bc_reg, br_reg;
    logic [CNT_W-1:0] pc_next, pr_next, bc_next, br_next;
    logic [FW-1:0]    px_reg, py_reg, px_next, py_next;
    logic [CNT_W-1:0] pc_cur, pr_cur, bc_cur, br_cur;
    logic [FW-1:0]    px_cur, py_cur;

    logic acc, cfg_acc, in_range, first, emit, done_now, room;
    logic [AW-1:0] addr_now;

    logic                 s1_valid_reg, s1_emit_reg, s1_first_reg, s1_fwd_reg;
    logic [AW-1:0]        s1_addr_reg;
    logic [OUT_POS_W-1:0] s1_col_reg, s1_row_reg;
    logic                 s1_done_reg;
    logic [FW-1:0]        s1_f_reg;
    logic                 s2_valid_reg, s2_done_reg;
    logic [OUT_POS_W-1:0] s2_col_reg, s2_row_reg;
    logic [RECIP_W-1:0]   s2_recip_reg;
    logic                 s3_valid_reg, s3_done_reg;
    logic [OUT_POS_W-1:0] s3_col_reg, s3_row_reg;
    logic [FIFO_CNT_W:0]  inflight;

    assign cfg.ready = 1'b1;
    assign cfg_acc   = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg  <= WIDTH_RST;
            img_h_reg  <= HEIGHT_RST;
            factor_reg <= FACTOR_RST;
            settle_reg <= 1'b1;
        end
        else
        begin
            settle_reg <= cfg_acc;
            if (cfg_acc)
            begin
                unique case (cfg.index)
                    CFG_IMAGE_WIDTH:  img_w_reg  <= cfg.data;
                    CFG_IMAGE_HEIGHT: img_h_reg  <= cfg.data;
                    CFG_SCALE_FACTOR: factor_reg <= cfg.data[FACTOR_REG_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // clamped sizes and reduced geometry, refreshed every cycle
    always_comb
    begin
        priority if (img_w_reg == '0)
            w_eff = CNT_W'(1);
        else if (int'(img_w_reg) > MAX_WIDTH)
            w_eff = CNT_W'(MAX_WIDTH);
        else
            w_eff = img_w_reg;

        priority if (img_h_reg == '0)
            h_eff = CNT_W'(1);
        else if (int'(img_h_reg) > MAX_HEIGHT)
            h_eff = CNT_W'(MAX_HEIGHT);
        else
            h_eff = img_h_reg;

        priority if (factor_reg == '0)
            f_eff = FW'(1);
        else if (int'(factor_reg) > MAX_FACTOR)
            f_eff = FW'(MAX_FACTOR);
        else
            f_eff = FW'(factor_reg);
    end

    assign size_rec = size_recip(FIDX_W'(f_eff));
    assign w_prod   = {{WREC_W{1'b0}}, w_eff} * {{CNT_W{1'b0}}, size_rec};
    assign h_prod   = {{WREC_W{1'b0}}, h_eff} * {{CNT_W{1'b0}}, size_rec};

    always_ff @(posedge clk)
    begin
        w_eff_reg <= w_eff;
        h_eff_reg <= h_eff;
        f_eff_reg <= f_eff;
        new_w_reg <= w_prod[WREC_SHIFT +: CNT_W];
        new_h_reg <= h_prod[WREC_SHIFT +: CNT_W];
    end

    // credit: output queue plus emitting beats still in flight
    assign inflight = (FIFO_CNT_W+1)'(level) + (FIFO_CNT_W+1)'(s1_emit_reg)
                    + (FIFO_CNT_W+1)'(s2_valid_reg) + (FIFO_CNT_W+1)'(s3_valid_reg);
    assign room        = inflight < (FIFO_CNT_W+1)'(FIFO_DEPTH);
    assign pixel.ready = room && !settle_reg;
    assign acc         = pixel.valid && pixel.ready;

    always_comb
    begin
        if (pixel.frame_start)
        begin
            pc_cur = '0;
            pr_cur = '0;
            bc_cur = '0;
            br_cur = '0;
            px_cur = '0;
            py_cur = '0;
        end
        else
        begin
            pc_cur = pc_reg;
            pr_cur = pr_reg;
            bc_cur = bc_reg;
            br_cur = br_reg;
            px_cur = px_reg;
            py_cur = py_reg;
        end
    end

    assign in_range = (bc_cur < new_w_reg) && (br_cur < new_h_reg);
    assign first    = (px_cur == '0) && (py_cur == '0);
    assign emit     = (({1'b0, px_cur} + 1'b1) == {1'b0, f_eff_reg})
                   && (({1'b0, py_cur} + 1'b1) == {1'b0, f_eff_reg});
    assign done_now = (({1'b0, bc_cur} + 1'b1) == {1'b0, new_w_reg})
                   && (({1'b0, br_cur} + 1'b1) == {1'b0, new_h_reg});
    assign addr_now = AW'(bc_cur);

    always_comb
    begin
        pc_next = pc_reg;
        pr_next = pr_reg;
        bc_next = bc_reg;
        br_next = br_reg;
        px_next = px_reg;
        py_next = py_reg;
        if (acc)
        begin
            if (({1'b0, px_cur} + 1'b1) >= {1'b0, f_eff_reg})
            begin
                px_next = '0;
                bc_next = bc_cur + 1'b1;
            end
            else
            begin
                px_next = px_cur + 1'b1;
                bc_next = bc_cur;
            end
            pr_next = pr_cur;
            py_next = py_cur;
            br_next = br_cur;
            if (({1'b0, pc_cur} + 1'b1) >= {1'b0, w_eff_reg})
            begin
                pc_next = '0;
                px_next = '0;
                bc_next = '0;
                if (({1'b0, py_cur} + 1'b1) >= {1'b0, f_eff_reg})
                begin
                    py_next = '0;
                    br_next = br_cur + 1'b1;
                end
                else
                begin
                    py_next = py_cur + 1'b1;
                end
                if (({1'b0, pr_cur} + 1'b1) >= {1'b0, h_eff_reg})
                begin
                    pr_next = '0;
                    py_next = '0;
                    br_next = '0;
                end
                else
                begin
                    pr_next = pr_cur + 1'b1;
                end
            end
            else
            begin
                pc_next = pc_cur + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg       <= '0;
            pr_reg       <= '0;
            bc_reg       <= '0;
            br_reg       <= '0;
            px_reg       <= '0;
            py_reg       <= '0;
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
            s1_first_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg       <= pc_next;
            pr_reg       <= pr_next;
            bc_reg       <= bc_next;
            br_reg       <= br_next;
            px_reg       <= px_next;
            py_reg       <= py_next;
            s1_valid_reg <= acc && in_range;
            s1_emit_reg  <= acc && in_range && emit;
            s1_first_reg <= first;
            // previous beat writes this entry at the same edge as our read
            s1_fwd_reg   <= acc && in_range && s1_valid_reg && (s1_addr_reg == addr_now);
            s2_valid_reg <= s1_emit_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_addr_reg <= addr_now;
            s1_col_reg  <= bc_cur[OUT_POS_W-1:0];
            s1_row_reg  <= br_cur[OUT_POS_W-1:0];
            s1_done_reg <= done_now;
            s1_f_reg    <= f_eff_reg;
        end
        if (s1_emit_reg)
        begin
            s2_col_reg   <= s1_col_reg;
            s2_row_reg   <= s1_row_reg;
            s2_done_reg  <= s1_done_reg;
            s2_recip_reg <= area_recip(FIDX_W'(s1_f_reg));
        end
        if (s2_valid_reg)
        begin
            s3_col_reg  <= s2_col_reg;
            s3_row_reg  <= s2_row_reg;
            s3_done_reg <= s2_done_reg;
        end
    end

    assign lane_ctl.acc    = acc;
    assign lane_ctl.wr     = s1_valid_reg;
    assign lane_ctl.first  = s1_first_reg;
    assign lane_ctl.fwd    = s1_fwd_reg;
    assign lane_ctl.ld_mul = s1_emit_reg;
    assign lane_ctl.mul    = s2_valid_reg;
    assign rd_addr         = addr_now;
    assign wr_addr         = s1_addr_reg;
    assign recip           = s2_recip_reg;

    assign meta.push = s3_valid_reg;
    assign meta.col  = s3_col_reg;
    assign meta.row  = s3_row_reg;
    assign meta.done = s3_done_reg;

    a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_acc |=> !pixel.ready)
        else $error("pixel accepted right after a config write");

    a_fwd_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fwd_reg |-> (s1_valid_reg && $past(s1_valid_reg)))
        else $error("forward without a preceding write");

    a_emit_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
        acc |-> (inflight < (FIFO_CNT_W+1)'(FIFO_DEPTH)))
        else $error("beat accepted without output credit");

endmodule

// File: hdl/bad_lane.sv
// ----------------------------------------------------------------------------
// bad_lane
// One component: column-sum line store, read/add/write-back with forwarding,
// then block mean by reciprocal multiply.
// ----------------------------------------------------------------------------
module bad_lane import bad_pkg::*; #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic               clk,
    input  lane_ctl_t          ctl,
    input  logic [AW-1:0]      rd_addr,
    input  logic [AW-1:0]      wr_addr,
    input  comp_t              px,
    input  logic [RECIP_W-1:0] recip,
    output comp_t              avg
);

    logic [SUM_W-1:0]         sum_mem [DEPTH];
    logic [SUM_W-1:0]         rd_data_reg;
    logic [SUM_W-1:0]         last_sum_reg;
    logic [SUM_W-1:0]         sum_reg;
    comp_t                    px_reg;
    logic [SUM_W-1:0]         base;
    logic [SUM_W-1:0]         sum;
    logic [SUM_W+RECIP_W-1:0] prod_reg;

    assign base = ctl.fwd ? last_sum_reg : rd_data_reg;
    assign sum  = ctl.first ? SUM_W'(px_reg) : base + SUM_W'(px_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.acc)
        begin
            rd_data_reg <= sum_mem[rd_addr];
            px_reg      <= px;
        end
        if (ctl.wr)
        begin
            sum_mem[wr_addr] <= sum;
            last_sum_reg     <= sum;
        end
        if (ctl.ld_mul)
            sum_reg <= sum;
        if (ctl.mul)
            prod_reg <= {{RECIP_W{1'b0}}, sum_reg} * {{SUM_W{1'b0}}, recip};
    end

    assign avg = prod_reg[RECIP_SHIFT +: COMP_W];

endmodule

// File: hdl/bad_merge.sv
// ----------------------------------------------------------------------------
// bad_merge
// Joins lane means with block position into one result beat and queues it
// toward the output channel.
// ----------------------------------------------------------------------------
module bad_merge import bad_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  res_meta_t             meta,
    input  comp_t                 avg [NUM_COMP_MAX],
    bad_res_if.source             result,
    output logic [FIFO_CNT_W-1:0] level
);

    typedef struct packed {
        comp_t [NUM_COMP_MAX-1:0] avg;
        logic [OUT_POS_W-1:0]     col;
        logic [OUT_POS_W-1:0]     row;
        logic                     done;
    } result_t;

    result_t                fifo_mem_reg [FIFO_DEPTH];
    result_t                wr_entry;
    result_t                rd_entry;
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]  count_reg;
    logic                   pop;

    always_comb
    begin
        for (int c = 0; c < NUM_COMP_MAX; c++)
            wr_entry.avg[c] = avg[c];
        wr_entry.col  = meta.col;
        wr_entry.row  = meta.row;
        wr_entry.done = meta.done;
    end

    assign pop = result.valid && result.ready;

    always_ff @(posedge clk)
    begin
        if (meta.push)
            fifo_mem_reg[wr_ptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (meta.push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            unique case ({meta.push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    assign rd_entry          = fifo_mem_reg[rd_ptr_reg];
    assign result.valid      = count_reg != '0;
    assign result.comp0_avg  = rd_entry.avg[0];
    assign result.comp1_avg  = rd_entry.avg[1];
    assign result.comp2_avg  = rd_entry.avg[2];
    assign result.comp3_avg  = rd_entry.avg[3];
    assign result.out_column = rd_entry.col;
    assign result.out_row    = rd_entry.row;
    assign result.frame_done = rd_entry.done;
    assign level             = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        meta.push |-> (count_reg < FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("result queue overflow");

endmodule

// File: hdl/box_average_downscaler_top.sv
// ----------------------------------------------------------------------------
// box_average_downscaler_top
// Box filter downscaler: per-component truncated mean over factor x factor
// blocks of a raster pixel stream, up to four lanes sharing one position pipeline.
//
//   channel   role    beat contents
//   pixel     sink    frame_start, comp0_in..comp3_in
//   result    source  comp0_avg..comp3_avg, out_column, out_row, frame_done
//   cfg       sink    index, data (width, height, factor)
//
// One pixel beat per clock while pixel.ready is high; a block's closing beat
// yields a result beat through line store read, add, multiply and queue.
// The line store is one read and one write per lane per cycle; back-to-back
// beats on one entry are forwarded.
// pixel.ready is low for one cycle after reset and after each cfg write.
// An 8-entry result queue with credit lets results stall without loss.
// ----------------------------------------------------------------------------
module box_average_downscaler_top import bad_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int COMPONENTS = 4,
    parameter int MAX_FACTOR = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    bad_pix_if.sink   pixel,
    bad_res_if.source result,
    bad_cfg_if.sink   cfg
);

    localparam int AW = $clog2(MAX_WIDTH);

    lane_ctl_t             lane_ctl;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic [RECIP_W-1:0]    recip;
    res_meta_t             meta;
    logic [FIFO_CNT_W-1:0] level;
    comp_t                 px  [NUM_COMP_MAX];
    comp_t                 avg [NUM_COMP_MAX];

    assign px[0] = pixel.comp0_in;
    assign px[1] = pixel.comp1_in;
    assign px[2] = pixel.comp2_in;
    assign px[3] = pixel.comp3_in;

    bad_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR),
        .AW         (AW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel    (pixel),
        .cfg      (cfg),
        .level    (level),
        .lane_ctl (lane_ctl),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .recip    (recip),
        .meta     (meta)
    );

    for (genvar c = 0; c < NUM_COMP_MAX; c++)
    begin : g_lane
        if (c < COMPONENTS)
        begin : g_on
            bad_lane #(
                .DEPTH (MAX_WIDTH),
                .AW    (AW)
            ) u_lane (
                .clk     (clk),
                .ctl     (lane_ctl),
                .rd_addr (rd_addr),
                .wr_addr (wr_addr),
                .px      (px[c]),
                .recip   (recip),
                .avg     (avg[c])
            );
        end
        else
        begin : g_off
            assign avg[c] = '0;
        end
    end

    bad_merge u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .meta   (meta),
        .avg    (avg),
        .result (result),
        .level  (level)
    );

endmodule

// File: tb/box_average_downscaler_top_tb.sv
// ----------------------------------------------------------------------------
// box_average_downscaler_top_tb
// Self-checking bench for the box average downscaler. Pixel beats go in with
// random gaps and the result channel is stalled at random. A behavioral
// block-mean predictor produces the expected mean beats, and a checker
// compares every result beat field by field. The bench covers reset
// defaults, clamped and extreme sizes, frame wrap and restart, a height
// change mid-frame, a long result stall, and random frame streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module box_average_downscaler_top_tb;
    import bad_pkg::*;

    localparam int LINE_DEPTH   = 1024;
    localparam int COMPONENTS   = 4;
    localparam int FACTOR_CAP   = 8;
    localparam int RANDOM_ITEMS = 400;
    localparam int DRAIN_SLACK  = 16;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 300000;

    typedef struct packed {
        comp_t [NUM_COMP_MAX-1:0] avg;
        logic [OUT_POS_W-1:0]     col;
        logic [OUT_POS_W-1:0]     row;
        logic                     done;
    } mean_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    bad_pix_if pix ();
    bad_res_if res ();
    bad_cfg_if cfg_ch ();

    box_average_downscaler_top #(
        .MAX_WIDTH  (LINE_DEPTH),
        .COMPONENTS (COMPONENTS),
        .MAX_FACTOR (FACTOR_CAP)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pix),
        .result (res),
        .cfg    (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [CNT_W-1:0]        width_reg  = WIDTH_RST;
    logic [CNT_W-1:0]        height_reg = HEIGHT_RST;
    logic [FACTOR_REG_W-1:0] factor_reg = FACTOR_RST;
    bit   [SUM_W-1:0]        col_sum [LINE_DEPTH][NUM_COMP_MAX];
    int unsigned x_pos, y_pos, x_phase, y_phase, blk_x, blk_y;

    mean_beat_t mean_q[$];
    int  err_count     = 0;
    int  means_checked = 0;
    int  pixels_sent   = 0;
    int  reg_writes    = 0;
    int  cycle_count   = 0;
    bit  idle_on       = 1'b1;
    bit  long_hold_req = 1'b0;

    function automatic int unsigned clamp_u(input int unsigned v, input int unsigned lo,
                                            input int unsigned hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic bit at_frame_origin();
        return x_pos == 0 && y_pos == 0 && x_phase == 0 && y_phase == 0 &&
               blk_x == 0 && blk_y == 0;
    endfunction

    function automatic bit downscale_step(input logic fs, input logic [31:0] comps,
                                          output mean_beat_t beat);
        int unsigned w, h, f, cols_out, rows_out, slot;
        logic [SUM_W-1:0] px;
        bit first, hit;
        w        = clamp_u(width_reg, 1, LINE_DEPTH);
        h        = clamp_u(height_reg, 1, MAX_HEIGHT);
        f        = clamp_u(factor_reg, 1, FACTOR_CAP);
        cols_out = w / f;
        rows_out = h / f;
        beat     = '0;
        hit      = 1'b0;
        if (fs)
        begin
            x_pos = 0; y_pos = 0; x_phase = 0; y_phase = 0; blk_x = 0; blk_y = 0;
        end
        if (blk_x < cols_out && blk_y < rows_out)
        begin
            slot  = blk_x % LINE_DEPTH;
            first = (x_phase == 0 && y_phase == 0);
            for (int c = 0; c < NUM_COMP_MAX; c++)
            begin
                px = (c < COMPONENTS) ? SUM_W'(comps[8*c +: 8]) : '0;
                col_sum[slot][c] = first ? px : col_sum[slot][c] + px;
            end
            if (x_phase == f - 1 && y_phase == f - 1)
            begin
                for (int c = 0; c < NUM_COMP_MAX; c++)
                    beat.avg[c] = (c < COMPONENTS) ? comp_t'(col_sum[slot][c] / (f * f)) : '0;
                beat.col  = OUT_POS_W'(blk_x);
                beat.row  = OUT_POS_W'(blk_y);
                beat.done = (blk_x == cols_out - 1 && blk_y == rows_out - 1);
                hit = 1'b1;
            end
        end
        if (x_phase + 1 >= f)
        begin
            x_phase = 0;
            blk_x++;
        end
        else
            x_phase++;
        if (x_pos + 1 >= w)
        begin
            x_pos   = 0;
            x_phase = 0;
            blk_x   = 0;
            if (y_phase + 1 >= f)
            begin
                y_phase = 0;
                blk_y++;
            end
            else
                y_phase++;
            if (y_pos + 1 >= h)
            begin
                y_pos   = 0;
                y_phase = 0;
                blk_y   = 0;
            end
            else
                y_pos++;
        end
        else
            x_pos++;
        blk_x &= 32'hFFFF;
        blk_y &= 32'hFFFF;
        return hit;
    endfunction

    // one pixel beat; starts and ends just after a falling edge
    task automatic send_pixel(input logic fs, input logic [31:0] comps);
        mean_beat_t beat;
        if (idle_on && $urandom_range(0, 99) < 8)
        begin
            pix.valid <= 1'b0;
            @(negedge clk);
        end
        pix.valid       <= 1'b1;
        pix.frame_start <= fs;
        pix.comp0_in    <= comps[7:0];
        pix.comp1_in    <= comps[15:8];
        pix.comp2_in    <= comps[23:16];
        pix.comp3_in    <= comps[31:24];
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
        @(negedge clk);
        if (downscale_step(fs, comps, beat))
            mean_q.push_back(beat);
        pixels_sent++;
    endtask

    task automatic drain_means();
        pix.valid <= 1'b0;
        while (mean_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_SLACK) @(negedge clk);
    endtask

    // a negative value leaves that register alone
    task automatic write_regs(input int w, input int h, input int f);
        int vals[3];
        logic [CFG_IDX_W-1:0] codes[3];
        vals  = '{w, h, f};
        codes = '{CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_SCALE_FACTOR};
        for (int i = 0; i < 3; i++)
        begin
            if (vals[i] < 0)
                continue;
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= codes[i];
            cfg_ch.data  <= CFG_DATA_W'(vals[i]);
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
            @(negedge clk);
            case (codes[i])
                CFG_IMAGE_WIDTH:  width_reg  = CNT_W'(vals[i]);
                CFG_IMAGE_HEIGHT: height_reg = CNT_W'(vals[i]);
                CFG_SCALE_FACTOR: factor_reg = FACTOR_REG_W'(vals[i]);
                default: ;
            endcase
            reg_writes++;
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        for (int i = 0; i < 642; i++)
            send_pixel(i == 0, $urandom());
        drain_means();
    endtask

    task automatic test_block_means();
        logic [31:0] words[8];
        words = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'h55FF0100, 32'hAAFF0100,
                  32'hFFFFFFFF, 32'hFFFFFFFF, 32'h55FF0100, 32'hAAFE0000};
        write_regs(4, 2, 2);
        for (int i = 0; i < 8; i++)
            send_pixel(i == 0, words[i]);
        drain_means();
    endtask

    task automatic test_identity_factor();
        logic [31:0] words[6];
        words = '{32'h00000000, 32'hFFFFFFFF, 32'h55AA55AA,
                  32'hAA55AA55, 32'h01020304, 32'h80808080};
        write_regs(3, 2, 1);
        for (int i = 0; i < 6; i++)
            send_pixel(i == 0, words[i]);
        drain_means();
    endtask

    task automatic test_oversized_factor();
        write_regs(2, 2, 15);
        for (int i = 0; i < 4; i++)
            send_pixel(i == 0, $urandom());
        drain_means();
    endtask

    task automatic test_zero_sizes();
        write_regs(0, 0, 0);
        for (int i = 0; i < 3; i++)
            send_pixel(i == 0, $urandom());
        drain_means();
    endtask

    // second frame by wrap, third by restart part way through
    task automatic test_frame_wrap_restart();
        write_regs(4, 2, 2);
        for (int i = 0; i < 21; i++)
            send_pixel(i == 0 || i == 13, $urandom());
        drain_means();
    endtask

    task automatic test_height_shrink();
        write_regs(4, 4, 2);
        for (int i = 0; i < 10; i++)
            send_pixel(i == 0, $urandom());
        drain_means();
        write_regs(-1, 2, -1);
        for (int i = 0; i < 10; i++)
            send_pixel(1'b0, $urandom());
        drain_means();
    endtask

    task automatic test_size_extremes();
        idle_on = 1'b0;
        write_regs(2047, 1, 1);
        for (int i = 0; i < 1024; i++)
            send_pixel(i == 0, $urandom());
        drain_means();
        write_regs(1, 2047, 1);
        for (int i = 0; i < 1024; i++)
            send_pixel(i == 0, $urandom());
        drain_means();
        idle_on = 1'b1;
        write_regs(16, 16, 15);
        for (int i = 0; i < 256; i++)
            send_pixel(i == 0, (i < 128) ? 32'hFFFFFFFF : $urandom());
        drain_means();
    endtask

    task automatic test_result_backpressure();
        write_regs(48, 1, 1);
        long_hold_req = 1'b1;
        for (int i = 0; i < 48; i++)
            send_pixel(i == 0, $urandom());
        drain_means();
    endtask

    task automatic test_random_frames();
        int unsigned f_reg, fe, w, h, total, n, frames;
        int sent;
        logic fs;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            f_reg = $urandom_range(1, 8);
            if ($urandom_range(0, 7) == 0)
                f_reg = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(9, 15);
            fe = clamp_u(f_reg, 1, FACTOR_CAP);
            w  = fe * $urandom_range(1, (fe > 4) ? 1 : 3) + $urandom_range(0, fe - 1);
            h  = fe * $urandom_range(1, (fe > 4) ? 1 : 3) + $urandom_range(0, fe - 1);
            drain_means();
            write_regs(w, h, f_reg);
            frames = $urandom_range(1, 3);
            repeat (frames)
            begin
                total = w * h;
                n = (total > 1 && $urandom_range(0, 5) == 0) ? $urandom_range(1, total - 1)
                                                              : total;
                for (int i = 0; i < n; i++)
                begin
                    if (i == 0)
                        fs = at_frame_origin() ? ($urandom_range(0, 3) != 0) : 1'b1;
                    else
                        fs = ($urandom_range(0, 99) == 0);
                    send_pixel(fs, $urandom());
                end
                sent += n;
            end
        end
        drain_means();
    endtask

    // result sink: random stalls plus one long hold on request
    initial
    begin
        res.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                res.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold_req = 1'b0;
            end
            res.ready <= !(idle_on && $urandom_range(0, 99) < 8);
        end
    end

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            err_count++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_means
        mean_beat_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (mean_q.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected result beat: expected none, got col %0d row %0d",
                         $time, res.out_column, res.out_row);
            end
            else
            begin
                want = mean_q.pop_front();
                check_field("comp0_avg", want.avg[0], res.comp0_avg);
                check_field("comp1_avg", want.avg[1], res.comp1_avg);
                check_field("comp2_avg", want.avg[2], res.comp2_avg);
                check_field("comp3_avg", want.avg[3], res.comp3_avg);
                check_field("out_column", want.col, res.out_column);
                check_field("out_row", want.row, res.out_row);
                check_field("frame_done", want.done, res.frame_done);
                means_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, mean_q.size());
            $display("box_average_downscaler_top regression: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        pix.valid        = 1'b0;
        pix.frame_start  = 1'b0;
        pix.comp0_in     = '0;
        pix.comp1_in     = '0;
        pix.comp2_in     = '0;
        pix.comp3_in     = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_IMAGE_WIDTH;
        cfg_ch.data      = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_block_means();
        test_identity_factor();
        test_oversized_factor();
        test_zero_sizes();
        test_frame_wrap_restart();
        test_height_shrink();
        test_size_extremes();
        test_result_backpressure();
        test_random_frames();

        $display("%0d pixel beats sent, %0d mean beats checked, %0d register writes",
                 pixels_sent, means_checked, reg_writes);
        $display("covered reset sizes, clamped sizes, factors 1 to 8, frame wrap, restart, ",
                 "height change mid-frame, long result stall, random frames");
        if (err_count == 0)
            $display("box_average_downscaler_top regression: pass");
        else
            $display("box_average_downscaler_top regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
hdl/bad_pkg.sv
hdl/bad_pix_if.sv
hdl/bad_res_if.sv
hdl/bad_cfg_if.sv
hdl/bad_ctrl.sv
hdl/bad_lane.sv
hdl/bad_merge.sv
hdl/box_average_downscaler_top.sv
tb/box_average_downscaler_top_tb.sv
